/* src/msbr_pkg.sv */
// Shared types and constants for the MSB-first bit reader.
// No dependencies; imported by msbr_exec and msb_first_bit_reader.
`default_nettype none
package msbr_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned AVAIL_W   = 7;

  typedef enum logic [2:0] {
    REQ_PUSH       = 3'd0,
    REQ_GET        = 3'd1,
    REQ_PEEK       = 3'd2,
    REQ_PEEK_CLAMP = 3'd3,
    REQ_FLUSH      = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HOLD     = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic [5:0] num_bits;
  } req_t;

  typedef struct packed {
    logic [31:0]        value;
    logic [1:0]         status;
    logic [AVAIL_W-1:0] bits_available;
  } rsp_t;

endpackage
`default_nettype wire

/* src/msbr_exec.sv */
// Combinational datapath of the bit reader: decodes one request against the
// current store and count, gives the next state and the result. Uses msbr_pkg.
`default_nettype none
module msbr_exec #(
  parameter int unsigned STORE_BITS    = 64,
  parameter int unsigned MAX_PEEK_BITS = 24,
  localparam int unsigned CNT_W        = $clog2(STORE_BITS + 1)
) (
  input  wire logic [STORE_BITS-1:0] store_i,
  input  wire logic [CNT_W-1:0]      held_i,
  input  wire msbr_pkg::req_t        req_i,
  output logic      [STORE_BITS-1:0] store_o,
  output logic      [CNT_W-1:0]      held_o,
  output msbr_pkg::rsp_t             rsp_o
);
  import msbr_pkg::*;

  // compare width: holds counts, num_bits and count + 8
  localparam int unsigned CW    = ((CNT_W > 6) ? CNT_W : 6) + 1;
  localparam int unsigned EXT_W = CNT_W + AVAIL_W;

  logic [CW-1:0]        held_w, n_raw, get_n, peek_n, clamp_n, n_w, sh, lsh, push_sum;
  logic [STORE_BITS-1:0] shifted;
  logic [WORD_BITS:0]   mask;
  logic [31:0]          right_val, left_val;
  logic                 short;
  logic [EXT_W-1:0]     held_ext;

  always_comb begin
    held_w   = CW'(held_i);
    n_raw    = CW'(req_i.num_bits);
    get_n    = (n_raw > CW'(WORD_BITS)) ? CW'(WORD_BITS) : n_raw;
    peek_n   = (n_raw > CW'(MAX_PEEK_BITS)) ? CW'(MAX_PEEK_BITS) : n_raw;
    clamp_n  = (peek_n > held_w) ? held_w : peek_n;
    push_sum = held_w + CW'(8);

    case (req_i.req_type)
      REQ_PEEK:       n_w = peek_n;
      REQ_PEEK_CLAMP: n_w = clamp_n;
      default:        n_w = get_n;
    endcase

    short = (n_w > held_w);

    // oldest n bits sit at [held-1 : held-n]
    sh        = held_w - n_w;
    shifted   = store_i >> sh;
    mask      = ((WORD_BITS + 1)'(1) << n_w) - (WORD_BITS + 1)'(1);
    right_val = shifted[31:0] & mask[31:0];
    lsh       = CW'(WORD_BITS) - n_w;
    left_val  = right_val << lsh;

    store_o = store_i;
    held_o  = held_i;
    rsp_o.value  = '0;
    rsp_o.status = ST_OK;

    unique case (req_i.req_type)
      REQ_PUSH: begin
        if (push_sum > CW'(STORE_BITS)) begin
          rsp_o.status = ST_OVERFLOW;
        end else begin
          store_o = {store_i[STORE_BITS-9:0], req_i.data_byte};
          held_o  = CNT_W'(push_sum);
        end
      end
      REQ_GET, REQ_FLUSH: begin
        if (short) begin
          rsp_o.status = ST_HOLD;
        end else begin
          held_o = CNT_W'(held_w - n_w);
          if (req_i.req_type == REQ_GET) begin
            rsp_o.value = right_val;
          end
        end
      end
      REQ_PEEK: begin
        if (short) begin
          rsp_o.status = ST_HOLD;
        end else begin
          rsp_o.value = left_val;
        end
      end
      REQ_PEEK_CLAMP: begin
        rsp_o.value = left_val;
      end
      default: begin
        // unused codes: no operation
      end
    endcase

    held_ext             = EXT_W'(held_o);
    rsp_o.bits_available = held_ext[AVAIL_W-1:0];
  end

endmodule
`default_nettype wire

/* src/msb_first_bit_reader.sv */
// MSB-first bit reader top level: input register, datapath, result register.
// Depends on msbr_pkg and msbr_exec.
// Accepted items load the input reg, then the result reg once the result slot is free.
// Throughput: 1 item per cycle unless the output stalls; the store/count update in msbr_exec sets it.
// Reset: asynchronous active-low; clears store, bit count and both valid flags.
`default_nettype none
module msb_first_bit_reader #(
  parameter int unsigned STORE_BITS    = 64,
  parameter int unsigned MAX_PEEK_BITS = 24
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire msbr_pkg::req_t in_item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output msbr_pkg::rsp_t      out_item_o
);
  import msbr_pkg::*;

  localparam int unsigned CNT_W = $clog2(STORE_BITS + 1);

  // input stage
  logic s1_valid_q;
  req_t s1_item_q;

  // result stage
  logic out_valid_q;
  rsp_t out_item_q;

  // bit store: newest bits at the low end, oldest at bit held_q-1
  logic [STORE_BITS-1:0] store_q, store_d;
  logic [CNT_W-1:0]      held_q, held_d;
  rsp_t                  rsp;

  logic s1_move; // input-stage item moves into the result register

  // result slot free now or freed this cycle
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;

  msbr_exec #(
    .STORE_BITS    (STORE_BITS),
    .MAX_PEEK_BITS (MAX_PEEK_BITS)
  ) u_exec (
    .store_i (store_q),
    .held_i  (held_q),
    .req_i   (s1_item_q),
    .store_o (store_d),
    .held_o  (held_d),
    .rsp_o   (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      store_q     <= '0;
      held_q      <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      // state commits only when the item's result is registered
      if (s1_move) begin
        out_valid_q <= 1'b1;
        store_q     <= store_d;
        held_q      <= held_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (s1_move) begin
      out_item_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire
